/* rtl/core/ladder_vcf_four_pole_unit_defines.svh */
// Assertion macros for the ladder filter checker.
// No dependencies.
`ifndef LADDER_VCF_FOUR_POLE_UNIT_DEFINES_SVH
`define LADDER_VCF_FOUR_POLE_UNIT_DEFINES_SVH
// implication checked on every clock unless in reset
`define LVF_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lvf check failed");
// next-cycle implication
`define LVF_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lvf check failed");
`endif

/* rtl/core/lvf_pkg.sv */
// Shared constants and types for the ladder filter.
// No dependencies.
package lvf_pkg;
	localparam int ST_W = 24;
	localparam int CO_W = 20;
	localparam int CO_FRAC = 16;
	localparam int ST_FRAC = 20;
	localparam int DIG_W = 4;
	localparam logic signed [ST_W-1:0] ST_MAX = 24'sh7FFFFF;
	localparam logic signed [ST_W-1:0] ST_MIN = -24'sh800000;
	localparam logic signed [ST_W:0] SIXTH_Q20 = 25'sd174763;

	localparam logic [2:0] REG_ENABLE = 3'd0;
	localparam logic [2:0] REG_MODE   = 3'd1;
	localparam logic [2:0] REG_GAIN   = 3'd2;
	localparam logic [2:0] REG_FBK    = 3'd3;
	localparam logic [2:0] REG_RES    = 3'd4;

	localparam logic [1:0] MODE_SILENT = 2'd0;
	localparam logic [1:0] MODE_LP     = 2'd1;
	localparam logic [1:0] MODE_BP     = 2'd2;
	localparam logic [1:0] MODE_HP     = 2'd3;

	// sequencer steps; ST_FB through ST_SIX each run a digit-serial multiply-accumulate
	typedef enum logic [10:0] {
		ST_IDLE = 11'b00000000001,
		ST_FB   = 11'b00000000010,
		ST_P1   = 11'b00000000100,
		ST_P2   = 11'b00000001000,
		ST_P3   = 11'b00000010000,
		ST_P4   = 11'b00000100000,
		ST_SQ   = 11'b00001000000,
		ST_CU   = 11'b00010000000,
		ST_SIX  = 11'b00100000000,
		ST_OUT  = 11'b01000000000,
		ST_SEND = 11'b10000000000
	} seq_t;

	function automatic logic signed [ST_W-1:0] sat_st(input logic signed [63:0] v);
		if (v > 64'(ST_MAX)) return ST_MAX;
		if (v < 64'(ST_MIN)) return ST_MIN;
		return v[ST_W-1:0];
	endfunction
endpackage

/* rtl/core/lvf_mac.sv */
// Digit-serial multiply-accumulate: a*m (- c*n) over 4-bit multiplier digits.
// Depends on lvf_pkg.
module lvf_mac
	import lvf_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic signed [31:0]  a,
	input  logic signed [25:0]  m,
	input  logic signed [31:0]  c,
	input  logic signed [25:0]  n,
	output logic                done,
	output logic signed [63:0]  acc
);
	localparam int STEPS = 28 / DIG_W;
	logic [2:0] cnt_q;
	logic busy_q;
	logic signed [63:0] acc_q, a_q, c_q;
	logic [27:0] m_q, n_q;
	logic signed [63:0] pa, pc;
	logic last;

	assign last = (cnt_q == 3'(STEPS - 1));
	// top digit carries the sign weight
	always_comb begin
		if (last) begin
			pa = a_q * 64'($signed(m_q[DIG_W-1:0]));
			pc = c_q * 64'($signed(n_q[DIG_W-1:0]));
		end else begin
			pa = a_q * 64'($signed({1'b0, m_q[DIG_W-1:0]}));
			pc = c_q * 64'($signed({1'b0, n_q[DIG_W-1:0]}));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 3'd1;
				if (last) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			a_q <= 64'(a);
			c_q <= 64'(c);
			m_q <= 28'(m);
			n_q <= 28'(n);
		end else if (busy_q) begin
			acc_q <= acc_q + pa - pc;
			a_q <= a_q <<< DIG_W;
			c_q <= c_q <<< DIG_W;
			m_q <= m_q >> DIG_W;
			n_q <= n_q >> DIG_W;
		end
	end
	assign acc = acc_q;
endmodule

/* rtl/core/ladder_vcf_four_pole_unit.sv */
// Four-pole ladder filter top level: sequencer, state and stream ports.
// Depends on lvf_pkg and lvf_mac.
// A filtered sample is valid after its transfer when eight products (feedback,
// four poles, two cube steps, the sixth scale) run one after another through one
// digit-serial multiplier, each as a start, seven 4-bit digits and a hand-over,
// and ST_OUT and ST_SEND format it. Bypassed samples are valid the cycle after
// their transfer. One sample is in work at a time; the result waits in an output
// register and the next sample is taken from the cycle after the result transfer.
module ladder_vcf_four_pole_unit
	import lvf_pkg::*;
#(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0] s_tdata, // sample_in
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [((SAMPLE_BITS+7)/8)*8-1:0] m_tdata, // sample_out
	input  logic                   cfg_we,
	input  logic [2:0]             cfg_index,
	input  logic [CO_W-1:0]        cfg_data
);
	localparam int DW = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam int SH = ST_FRAC - (SAMPLE_BITS - 1);

	logic en_q;
	logic [1:0] mode_q;
	logic signed [CO_W-1:0] p_q, f_q, q_q;
	logic signed [ST_W-1:0] prev_q, b1_q, b2_q, b3_q, b4_q, x_q, fb_q, t_q;
	// cube terms grow past the state width before the sixth scale
	logic signed [31:0] cube_q;
	logic [SAMPLE_BITS-1:0] out_q;
	logic ovalid_q;
	seq_t st_q;

	logic mstart;
	logic signed [31:0] ma, mc;
	logic signed [25:0] mm, mn;
	logic mdone;
	logic signed [63:0] macc, sh16, sh20;

	lvf_mac u_mac (
		.clk, .arst_n, .start(mstart), .a(ma), .m(mm), .c(mc), .n(mn),
		.done(mdone), .acc(macc)
	);
	assign sh16 = macc >>> CO_FRAC;
	assign sh20 = macc >>> ST_FRAC;

	assign s_tready = (st_q == ST_IDLE) && !ovalid_q;
	assign m_tvalid = ovalid_q;
	assign m_tdata = DW'(out_q);

	logic signed [ST_W-1:0] xin;
	always_comb begin
		logic signed [SAMPLE_BITS:0] c;
		c = $signed({1'b0, s_tdata[SAMPLE_BITS-1:0]}) - $signed((SAMPLE_BITS+1)'(1) <<< (SAMPLE_BITS-1));
		if (SH >= 0) xin = ST_W'(64'(c) <<< SH);
		else xin = ST_W'(64'(c) >>> (-SH));
	end

	// operand selection for each product step
	always_comb begin
		ma = '0; mm = '0; mc = '0; mn = '0;
		unique case (st_q)
			ST_FB: begin ma = 32'(q_q); mm = 26'(b4_q); end
			ST_P1: begin ma = 32'(p_q); mm = 26'(fb_q) + 26'(prev_q);
				mc = 32'(f_q); mn = 26'(b1_q); end
			ST_P2: begin ma = 32'(p_q); mm = 26'(b1_q) + 26'(t_q);
				mc = 32'(f_q); mn = 26'(b2_q); end
			ST_P3: begin ma = 32'(p_q); mm = 26'(b2_q) + 26'(t_q);
				mc = 32'(f_q); mn = 26'(b3_q); end
			ST_P4: begin ma = 32'(p_q); mm = 26'(b3_q) + 26'(t_q);
				mc = 32'(f_q); mn = 26'(b4_q); end
			ST_SQ: begin ma = 32'(b4_q); mm = 26'(b4_q); end
			ST_CU: begin ma = cube_q; mm = 26'(b4_q); end
			ST_SIX: begin ma = cube_q; mm = 26'(SIXTH_Q20); end
			default: ;
		endcase
	end

	logic go_q;
	assign mstart = go_q;

	function automatic logic [SAMPLE_BITS-1:0] to_smp(input logic signed [ST_W+2:0] v);
		logic signed [63:0] s;
		logic signed [63:0] hf;
		hf = 64'sd1 <<< (SAMPLE_BITS - 1);
		if (SH >= 0) s = 64'(v) >>> SH;
		else s = 64'(v) <<< (-SH);
		if (s > hf - 1) s = hf - 1;
		if (s < -hf) s = -hf;
		s = s + hf;
		return s[SAMPLE_BITS-1:0];
	endfunction

	logic signed [ST_W+2:0] bp, yv;
	always_comb begin
		bp = ((ST_W+3)'(b3_q) - (ST_W+3)'(b4_q)) * (ST_W+3)'(3);
		unique case (mode_q)
			MODE_LP: yv = (ST_W+3)'(b4_q);
			MODE_BP: yv = bp;
			MODE_HP: yv = (ST_W+3)'(fb_q) - bp - (ST_W+3)'(b4_q);
			default: yv = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q <= 1'b0; mode_q <= MODE_LP;
			p_q <= '0; f_q <= '0; q_q <= '0;
			prev_q <= '0; b1_q <= '0; b2_q <= '0; b3_q <= '0; b4_q <= '0;
			st_q <= ST_IDLE; ovalid_q <= 1'b0; go_q <= 1'b0;
		end else begin
			go_q <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_ENABLE: en_q <= cfg_data[0];
					REG_MODE: mode_q <= cfg_data[1:0];
					REG_GAIN: p_q <= cfg_data;
					REG_FBK: f_q <= cfg_data;
					REG_RES: q_q <= cfg_data;
					default: ;
				endcase
			end
			if (ovalid_q && m_tready) ovalid_q <= 1'b0;
			unique case (st_q)
				ST_IDLE: if (s_tvalid && s_tready) begin
					if (en_q) begin
						st_q <= ST_FB; go_q <= 1'b1;
					end else begin
						ovalid_q <= 1'b1;
					end
				end
				ST_FB: if (mdone) begin
					fb_q <= sat_st(64'(x_q) - sh16); st_q <= ST_P1; go_q <= 1'b1;
				end
				ST_P1: if (mdone) begin
					t_q <= b1_q; b1_q <= sat_st(sh16); st_q <= ST_P2; go_q <= 1'b1;
				end
				ST_P2: if (mdone) begin
					t_q <= b2_q; b2_q <= sat_st(sh16); st_q <= ST_P3; go_q <= 1'b1;
				end
				ST_P3: if (mdone) begin
					t_q <= b3_q; b3_q <= sat_st(sh16); st_q <= ST_P4; go_q <= 1'b1;
				end
				ST_P4: if (mdone) begin
					b4_q <= sat_st(sh16); st_q <= ST_SQ; go_q <= 1'b1;
				end
				ST_SQ: if (mdone) begin
					cube_q <= 32'(sh20); st_q <= ST_CU; go_q <= 1'b1;
				end
				ST_CU: if (mdone) begin
					cube_q <= 32'(sh20); st_q <= ST_SIX; go_q <= 1'b1;
				end
				ST_SIX: if (mdone) begin
					b4_q <= sat_st(64'(b4_q) - sh20); prev_q <= fb_q; st_q <= ST_OUT;
				end
				ST_OUT: st_q <= ST_SEND;
				ST_SEND: begin
					ovalid_q <= 1'b1; st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && s_tvalid && s_tready) begin
			x_q <= xin;
			out_q <= s_tdata[SAMPLE_BITS-1:0];
		end
		if (st_q == ST_SEND) out_q <= (mode_q == MODE_SILENT) ?
			SAMPLE_BITS'(1) << (SAMPLE_BITS - 1) : to_smp(yv);
	end
endmodule

/* rtl/core/lvf_checker.sv */
// Port-level checker for the ladder filter, bound to the top level.
// Depends on ladder_vcf_four_pole_unit_defines.svh.
`include "ladder_vcf_four_pole_unit_defines.svh"
module lvf_checker (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	input logic s_tready,
	input logic m_tvalid,
	input logic m_tready
);
	`LVF_ASSERT_NXT(a_stall_hold, m_tvalid && !m_tready, m_tvalid)
	`LVF_ASSERT_IMP(a_no_take_when_full, m_tvalid, !s_tready)
	`LVF_ASSERT_NXT(a_take_blocks, s_tvalid && s_tready, !s_tready)
endmodule

bind ladder_vcf_four_pole_unit lvf_checker u_lvf_checker (
	.clk, .arst_n, .s_tvalid, .s_tready, .m_tvalid, .m_tready
);
